FILE: rtl/core/qrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths, word layouts and case codes for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEF_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int TOL_W      = 16;
    localparam int STATUS_W   = 3;

    // b*b and a*c products, and the discriminant with the 4*a*c headroom
    localparam int PROD_W = 2 * COEF_WIDTH;
    localparam int DISC_W = PROD_W + 2;
    // square root result width
    localparam int SQRT_W = DISC_W / 2;
    // |c| << 2F divided by |a|
    localparam int D1_NW  = COEF_WIDTH + 2 * FRAC_BITS;
    localparam int D1_DW  = COEF_WIDTH;
    // |-b +- s| << F divided by |2a|, |a| or |b|
    localparam int N2_W   = SQRT_W + 1;
    localparam int D2_NW  = N2_W + FRAC_BITS;
    localparam int D2_DW  = COEF_WIDTH + 1;

    typedef logic signed [COEF_WIDTH-1:0] coef_t;

    typedef struct packed {
        coef_t coef_quadratic;
        coef_t coef_linear;
        coef_t coef_constant;
    } coef_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] root_status;
        coef_t               root_one;
        coef_t               root_two;
    } root_word_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE = 3'd0,
        ST_ONE  = 3'd1,
        ST_TWO  = 3'd2,
        ST_INF  = 3'd3,
        ST_OVF  = 3'd4
    } status_t;

    // equation class, settled once the discriminant is known
    typedef enum logic [3:0] {
        K_INF,   // a and b near zero
        K_LIN,   // a near zero: -c/b
        K_BZZ,   // b and c near zero: two zero roots
        K_BZ2,   // b near zero, +-sqrt(-c/a)
        K_BZ0,   // b near zero, no real root
        K_CZ,    // c near zero: 0 and -b/a
        K_BAND,  // discriminant near zero
        K_GEN,   // positive discriminant
        K_NEG    // negative discriminant
    } kind_t;

    typedef struct packed {
        kind_t                   kind;
        logic                    aneg;
        logic                    bneg;
        logic                    cneg;
        logic [COEF_WIDTH-1:0]   am;
        logic [COEF_WIDTH-1:0]   bm;
        logic [COEF_WIDTH-1:0]   cm;
        logic [DISC_W-1:0]       dm;
    } disc_ctx_t;

    typedef struct packed {
        kind_t               kind;
        logic                sign1;
        logic [SQRT_W-1:0]   root;
    } div_ctx_t;

endpackage

FILE: rtl/core/qrs_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface qrs_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/qrs_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_div_cell
// One restoring division step: takes one numerator bit, emits one quotient bit.
// ----------------------------------------------------------------------------
module qrs_div_cell #(
    parameter int  NW = 8,
    parameter int  DW = 8,
    parameter type side_t = logic
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [NW-1:0] in_nq,
    input  logic [DW-1:0] in_den,
    input  side_t         in_side,
    output logic          out_valid,
    output logic [DW-1:0] out_rem,
    output logic [NW-1:0] out_nq,
    output logic [DW-1:0] out_den,
    output side_t         out_side
);

    logic          valid_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [NW-1:0] nq_reg;
    logic [NW-1:0] nq_next;
    logic [DW-1:0] den_reg;
    side_t         side_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;

    always_comb
    begin
        trial    = {in_rem, in_nq[NW-1]};
        fits     = (trial >= {1'b0, in_den});
        diff     = trial - {1'b0, in_den};
        rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
        // numerator bits leave at the top, quotient bits enter at the bottom
        nq_next  = {in_nq[NW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            nq_reg   <= nq_next;
            den_reg  <= in_den;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_nq    = nq_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule

FILE: rtl/core/qrs_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// One digit-by-digit square root step: takes two operand bits, emits one
// root bit.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell #(
    parameter int  N = 8,
    parameter type side_t = logic
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [2*N-1:0] in_x,
    input  logic [N+1:0]   in_rem,
    input  logic [N-1:0]   in_root,
    input  side_t          in_side,
    output logic           out_valid,
    output logic [2*N-1:0] out_x,
    output logic [N+1:0]   out_rem,
    output logic [N-1:0]   out_root,
    output side_t          out_side
);

    logic           valid_reg;
    logic [2*N-1:0] x_reg;
    logic [2*N-1:0] x_next;
    logic [N+1:0]   rem_reg;
    logic [N+1:0]   rem_next;
    logic [N-1:0]   root_reg;
    logic [N-1:0]   root_next;
    side_t          side_reg;
    logic [N+3:0]   work;
    logic [N+3:0]   trial;
    logic [N+3:0]   diff;
    logic           fits;

    always_comb
    begin
        work      = {in_rem, in_x[2*N-1:2*N-2]};
        trial     = {2'b00, in_root, 2'b01};
        fits      = (work >= trial);
        diff      = work - trial;
        rem_next  = fits ? diff[N+1:0] : work[N+1:0];
        root_next = {in_root[N-2:0], fits};
        x_next    = {in_x[2*N-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule

FILE: rtl/core/quadratic_root_solver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_top
// Pipeline: a result word is registered at the output once its coefficient word
//   has passed 3 front stages, 64 divide cells, 33 square root cells, 1 setup
//   stage, 50 divide cells and the output register.
// Throughput: one word per cycle; the whole cell chain stalls while the output
//   word is held. Reset clears all valid bits and sets zero_tolerance to 3.
// ----------------------------------------------------------------------------
module quadratic_root_solver_top (
    input  logic               clk,
    input  logic               rst_n,
    qrs_stream_if.sink         coef,
    qrs_stream_if.source       roots,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int W  = qrs_pkg::COEF_WIDTH;
    localparam int F  = qrs_pkg::FRAC_BITS;
    localparam int TW = qrs_pkg::TOL_W;
    localparam logic REG_ZERO_TOL = 1'b0;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [TW-1:0] tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TW'(3);
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_ZERO_TOL))
        begin
            tol_reg <= pwdata[TW-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ZERO_TOL) ? 32'(tol_reg) : 32'd0;

    // ------------------------------------------------------------------
    // flow control: the input register aside, one enable for the whole chain
    // ------------------------------------------------------------------
    logic                    adv;
    logic                    ld0;
    logic                    out_valid_reg;
    qrs_pkg::root_word_t     out_word_reg;
    logic                    v0_reg;
    qrs_pkg::coef_word_t     s0_reg;

    assign adv         = !out_valid_reg || roots.ready;
    assign ld0         = !v0_reg || adv;
    assign coef.ready  = ld0;
    assign roots.valid = out_valid_reg;
    assign roots.data  = out_word_reg;

    // ------------------------------------------------------------------
    // stage 0: input register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (ld0)
        begin
            v0_reg <= coef.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld0)
        begin
            s0_reg <= coef.data;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: magnitudes, zero flags, products
    // ------------------------------------------------------------------
    logic [W-1:0]               ua;
    logic [W-1:0]               ub;
    logic [W-1:0]               uc;
    logic                       aneg_next;
    logic                       bneg_next;
    logic                       cneg_next;
    logic [W-1:0]               am_next;
    logic [W-1:0]               bm_next;
    logic [W-1:0]               cm_next;
    logic                       v1_reg;
    logic                       aneg1_reg;
    logic                       bneg1_reg;
    logic                       cneg1_reg;
    logic [W-1:0]               am1_reg;
    logic [W-1:0]               bm1_reg;
    logic [W-1:0]               cm1_reg;
    logic                       az1_reg;
    logic                       bz1_reg;
    logic                       cz1_reg;
    logic [qrs_pkg::PROD_W-1:0] bb1_reg;
    logic [qrs_pkg::PROD_W-1:0] ac1_reg;

    always_comb
    begin
        ua        = s0_reg.coef_quadratic;
        ub        = s0_reg.coef_linear;
        uc        = s0_reg.coef_constant;
        aneg_next = ua[W-1];
        bneg_next = ub[W-1];
        cneg_next = uc[W-1];
        am_next   = aneg_next ? (~ua + 1'b1) : ua;
        bm_next   = bneg_next ? (~ub + 1'b1) : ub;
        cm_next   = cneg_next ? (~uc + 1'b1) : uc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            aneg1_reg <= aneg_next;
            bneg1_reg <= bneg_next;
            cneg1_reg <= cneg_next;
            am1_reg   <= am_next;
            bm1_reg   <= bm_next;
            cm1_reg   <= cm_next;
            az1_reg   <= (am_next == '0) || (am_next < W'(tol_reg));
            bz1_reg   <= (bm_next == '0) || (bm_next < W'(tol_reg));
            cz1_reg   <= (cm_next == '0) || (cm_next < W'(tol_reg));
            bb1_reg   <= qrs_pkg::PROD_W'(bm_next) * qrs_pkg::PROD_W'(bm_next);
            ac1_reg   <= qrs_pkg::PROD_W'(am_next) * qrs_pkg::PROD_W'(cm_next);
        end
    end

    // ------------------------------------------------------------------
    // stage 2: discriminant and equation class
    // ------------------------------------------------------------------
    logic [qrs_pkg::DISC_W-1:0] bbx;
    logic [qrs_pkg::DISC_W-1:0] ac4;
    logic [qrs_pkg::DISC_W-1:0] dm;
    logic                       dneg;
    logic                       band;
    qrs_pkg::disc_ctx_t         ctx2_next;
    logic                       v2_reg;
    qrs_pkg::disc_ctx_t         ctx2_reg;

    always_comb
    begin
        bbx = qrs_pkg::DISC_W'(bb1_reg);
        ac4 = {ac1_reg, 2'b00};
        if (aneg1_reg != cneg1_reg)
        begin
            dm   = bbx + ac4;
            dneg = 1'b0;
        end
        else if (bbx >= ac4)
        begin
            dm   = bbx - ac4;
            dneg = 1'b0;
        end
        else
        begin
            dm   = ac4 - bbx;
            dneg = 1'b1;
        end
        band = (dm == '0) || (dm < (qrs_pkg::DISC_W'(tol_reg) << F));

        ctx2_next.aneg = aneg1_reg;
        ctx2_next.bneg = bneg1_reg;
        ctx2_next.cneg = cneg1_reg;
        ctx2_next.am   = am1_reg;
        ctx2_next.bm   = bm1_reg;
        // a near-zero c gives a zero linear root
        ctx2_next.cm   = cz1_reg ? '0 : cm1_reg;
        ctx2_next.dm   = dm;
        if (az1_reg && bz1_reg)
        begin
            ctx2_next.kind = qrs_pkg::K_INF;
        end
        else if (az1_reg)
        begin
            ctx2_next.kind = qrs_pkg::K_LIN;
        end
        else if (bz1_reg)
        begin
            if (cz1_reg)
            begin
                ctx2_next.kind = qrs_pkg::K_BZZ;
            end
            else if (cneg1_reg != aneg1_reg)
            begin
                ctx2_next.kind = qrs_pkg::K_BZ2;
            end
            else
            begin
                ctx2_next.kind = qrs_pkg::K_BZ0;
            end
        end
        else if (cz1_reg)
        begin
            ctx2_next.kind = qrs_pkg::K_CZ;
        end
        else if (band)
        begin
            ctx2_next.kind = qrs_pkg::K_BAND;
        end
        else if (dneg)
        begin
            ctx2_next.kind = qrs_pkg::K_NEG;
        end
        else
        begin
            ctx2_next.kind = qrs_pkg::K_GEN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx2_reg <= ctx2_next;
        end
    end

    // ------------------------------------------------------------------
    // first divider chain: (|c| << 2F) / |a|
    // ------------------------------------------------------------------
    localparam int D1N = qrs_pkg::D1_NW;
    localparam int D1D = qrs_pkg::D1_DW;

    logic               d1_valid [0:D1N];
    logic [D1D-1:0]     d1_rem   [0:D1N];
    logic [D1N-1:0]     d1_nq    [0:D1N];
    logic [D1D-1:0]     d1_den   [0:D1N];
    qrs_pkg::disc_ctx_t d1_side  [0:D1N];

    assign d1_valid[0] = v2_reg;
    assign d1_rem[0]   = '0;
    assign d1_nq[0]    = D1N'(ctx2_reg.cm) << (2 * F);
    assign d1_den[0]   = ctx2_reg.am;
    assign d1_side[0]  = ctx2_reg;

    for (genvar i = 0; i < D1N; i++)
    begin : g_d1
        qrs_div_cell #(
            .NW     (D1N),
            .DW     (D1D),
            .side_t (qrs_pkg::disc_ctx_t)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (d1_valid[i]),
            .in_rem    (d1_rem[i]),
            .in_nq     (d1_nq[i]),
            .in_den    (d1_den[i]),
            .in_side   (d1_side[i]),
            .out_valid (d1_valid[i+1]),
            .out_rem   (d1_rem[i+1]),
            .out_nq    (d1_nq[i+1]),
            .out_den   (d1_den[i+1]),
            .out_side  (d1_side[i+1])
        );
    end

    // ------------------------------------------------------------------
    // square root chain: discriminant, or the quotient in class K_BZ2, where b is near zero
    // ------------------------------------------------------------------
    localparam int SN = qrs_pkg::SQRT_W;

    logic               sq_valid [0:SN];
    logic [2*SN-1:0]    sq_x     [0:SN];
    logic [SN+1:0]      sq_rem   [0:SN];
    logic [SN-1:0]      sq_root  [0:SN];
    qrs_pkg::disc_ctx_t sq_side  [0:SN];

    assign sq_valid[0] = d1_valid[D1N];
    assign sq_x[0]     = (d1_side[D1N].kind == qrs_pkg::K_BZ2) ?
                         (2 * SN)'(d1_nq[D1N]) : d1_side[D1N].dm;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_side[0]  = d1_side[D1N];

    for (genvar i = 0; i < SN; i++)
    begin : g_sq
        qrs_sqrt_cell #(
            .N      (SN),
            .side_t (qrs_pkg::disc_ctx_t)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (sq_valid[i]),
            .in_x      (sq_x[i]),
            .in_rem    (sq_rem[i]),
            .in_root   (sq_root[i]),
            .in_side   (sq_side[i]),
            .out_valid (sq_valid[i+1]),
            .out_x     (sq_x[i+1]),
            .out_rem   (sq_rem[i+1]),
            .out_root  (sq_root[i+1]),
            .out_side  (sq_side[i+1])
        );
    end

    // ------------------------------------------------------------------
    // stage 3: numerators and divisor for the root quotients
    // ------------------------------------------------------------------
    localparam int NM  = qrs_pkg::N2_W;
    localparam int D2N = qrs_pkg::D2_NW;
    localparam int D2D = qrs_pkg::D2_DW;

    qrs_pkg::disc_ctx_t sctx;
    logic [NM-1:0]      bmx;
    logic [NM-1:0]      sx;
    logic               nbneg;
    logic [NM-1:0]      n1m;
    logic               n1s;
    logic [NM-1:0]      n2m;
    logic               n2s;
    logic [NM-1:0]      num1_next;
    logic [NM-1:0]      num2_next;
    logic [D2D-1:0]     den3_next;
    logic               sign2_next;
    qrs_pkg::div_ctx_t  dctx_next;
    logic               v3_reg;
    logic [NM-1:0]      num1_reg;
    logic [NM-1:0]      num2_reg;
    logic [D2D-1:0]     den3_reg;
    logic               sign2_reg;
    qrs_pkg::div_ctx_t  dctx_reg;

    always_comb
    begin
        sctx  = sq_side[SN];
        bmx   = NM'(sctx.bm);
        sx    = NM'(sq_root[SN]);
        nbneg = !sctx.bneg;
        // -b + s
        if (!nbneg)
        begin
            n1m = bmx + sx;
            n1s = 1'b0;
        end
        else if (bmx >= sx)
        begin
            n1m = bmx - sx;
            n1s = 1'b1;
        end
        else
        begin
            n1m = sx - bmx;
            n1s = 1'b0;
        end
        // -b - s
        if (nbneg)
        begin
            n2m = bmx + sx;
            n2s = 1'b1;
        end
        else if (bmx >= sx)
        begin
            n2m = bmx - sx;
            n2s = 1'b0;
        end
        else
        begin
            n2m = sx - bmx;
            n2s = 1'b1;
        end

        num1_next       = '0;
        num2_next       = '0;
        den3_next       = {sctx.am, 1'b0};
        sign2_next      = 1'b0;
        dctx_next.kind  = sctx.kind;
        dctx_next.sign1 = 1'b0;
        dctx_next.root  = sq_root[SN];
        case (sctx.kind)
            qrs_pkg::K_LIN:
            begin
                num1_next       = NM'(sctx.cm);
                den3_next       = D2D'(sctx.bm);
                dctx_next.sign1 = !sctx.cneg ^ sctx.bneg;
            end
            qrs_pkg::K_CZ:
            begin
                num2_next  = bmx;
                den3_next  = D2D'(sctx.am);
                sign2_next = nbneg ^ sctx.aneg;
            end
            qrs_pkg::K_BAND:
            begin
                num1_next       = bmx;
                num2_next       = bmx;
                dctx_next.sign1 = nbneg ^ sctx.aneg;
                sign2_next      = nbneg ^ sctx.aneg;
            end
            qrs_pkg::K_GEN:
            begin
                num1_next       = n1m;
                num2_next       = n2m;
                dctx_next.sign1 = n1s ^ sctx.aneg;
                sign2_next      = n2s ^ sctx.aneg;
            end
            default:
            begin
                num1_next = '0;
                num2_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= sq_valid[SN];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num1_reg  <= num1_next;
            num2_reg  <= num2_next;
            den3_reg  <= den3_next;
            sign2_reg <= sign2_next;
            dctx_reg  <= dctx_next;
        end
    end

    // ------------------------------------------------------------------
    // root divider chains, one per root
    // ------------------------------------------------------------------
    logic              da_valid [0:D2N];
    logic [D2D-1:0]    da_rem   [0:D2N];
    logic [D2N-1:0]    da_nq    [0:D2N];
    logic [D2D-1:0]    da_den   [0:D2N];
    qrs_pkg::div_ctx_t da_side  [0:D2N];
    logic              db_valid [0:D2N];
    logic [D2D-1:0]    db_rem   [0:D2N];
    logic [D2N-1:0]    db_nq    [0:D2N];
    logic [D2D-1:0]    db_den   [0:D2N];
    logic              db_side  [0:D2N];

    assign da_valid[0] = v3_reg;
    assign da_rem[0]   = '0;
    assign da_nq[0]    = D2N'(num1_reg) << F;
    assign da_den[0]   = den3_reg;
    assign da_side[0]  = dctx_reg;
    assign db_valid[0] = v3_reg;
    assign db_rem[0]   = '0;
    assign db_nq[0]    = D2N'(num2_reg) << F;
    assign db_den[0]   = den3_reg;
    assign db_side[0]  = sign2_reg;

    for (genvar i = 0; i < D2N; i++)
    begin : g_d2
        qrs_div_cell #(
            .NW     (D2N),
            .DW     (D2D),
            .side_t (qrs_pkg::div_ctx_t)
        ) u_cell_a (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (da_valid[i]),
            .in_rem    (da_rem[i]),
            .in_nq     (da_nq[i]),
            .in_den    (da_den[i]),
            .in_side   (da_side[i]),
            .out_valid (da_valid[i+1]),
            .out_rem   (da_rem[i+1]),
            .out_nq    (da_nq[i+1]),
            .out_den   (da_den[i+1]),
            .out_side  (da_side[i+1])
        );

        qrs_div_cell #(
            .NW     (D2N),
            .DW     (D2D),
            .side_t (logic)
        ) u_cell_b (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (db_valid[i]),
            .in_rem    (db_rem[i]),
            .in_nq     (db_nq[i]),
            .in_den    (db_den[i]),
            .in_side   (db_side[i]),
            .out_valid (db_valid[i+1]),
            .out_rem   (db_rem[i+1]),
            .out_nq    (db_nq[i+1]),
            .out_den   (db_den[i+1]),
            .out_side  (db_side[i+1])
        );
    end

    // ------------------------------------------------------------------
    // saturation and output register
    // ------------------------------------------------------------------
    // returns {overflow, value}
    function automatic logic [W:0] saturate(input logic [D2N-1:0] mag, input logic neg);
        logic [D2N-1:0] limit;
        logic [D2N-1:0] m;
        logic           ovf;
        logic [W-1:0]   v;
        limit = (D2N'(1) << (W - 1)) - D2N'(!neg);
        ovf   = (mag > limit);
        m     = ovf ? limit : mag;
        v     = neg ? (~m[W-1:0] + 1'b1) : m[W-1:0];
        return {ovf, v};
    endfunction

    qrs_pkg::div_ctx_t   fctx;
    logic [D2N-1:0]      mag1;
    logic [D2N-1:0]      mag2;
    logic                neg1;
    logic                neg2;
    qrs_pkg::status_t    st;
    logic [W:0]          enc1;
    logic [W:0]          enc2;
    qrs_pkg::root_word_t word_next;

    always_comb
    begin
        fctx = da_side[D2N];
        mag1 = '0;
        mag2 = '0;
        neg1 = 1'b0;
        neg2 = 1'b0;
        st   = qrs_pkg::ST_NONE;
        case (fctx.kind)
            qrs_pkg::K_INF:
            begin
                st = qrs_pkg::ST_INF;
            end
            qrs_pkg::K_LIN:
            begin
                st   = qrs_pkg::ST_ONE;
                mag1 = da_nq[D2N];
                neg1 = fctx.sign1;
            end
            qrs_pkg::K_BZZ:
            begin
                st = qrs_pkg::ST_TWO;
            end
            qrs_pkg::K_BZ2:
            begin
                st   = qrs_pkg::ST_TWO;
                mag1 = D2N'(fctx.root);
                mag2 = D2N'(fctx.root);
                neg2 = 1'b1;
            end
            qrs_pkg::K_CZ:
            begin
                st   = qrs_pkg::ST_TWO;
                mag2 = db_nq[D2N];
                neg2 = db_side[D2N];
            end
            qrs_pkg::K_BAND, qrs_pkg::K_GEN:
            begin
                st   = qrs_pkg::ST_TWO;
                mag1 = da_nq[D2N];
                neg1 = fctx.sign1;
                mag2 = db_nq[D2N];
                neg2 = db_side[D2N];
            end
            default:
            begin
                st = qrs_pkg::ST_NONE;
            end
        endcase
        enc1                  = saturate(mag1, neg1);
        enc2                  = saturate(mag2, neg2);
        word_next.root_one    = enc1[W-1:0];
        word_next.root_two    = enc2[W-1:0];
        word_next.root_status = (enc1[W] || enc2[W]) ? qrs_pkg::ST_OVF : st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= da_valid[D2N] && db_valid[D2N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_word_reg <= word_next;
        end
    end

endmodule
